[sv/utf8_ngram_tokenizer_core_macros.svh]
// ----------------------------------------------------------------------------
// UTF-8 n-gram tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_NGRAM_TOKENIZER_CORE_MACROS_SVH
`define UTF8_NGRAM_TOKENIZER_CORE_MACROS_SVH

// Property that must hold at every edge out of reset
`define UNGT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define UNGT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ungt_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 n-gram tokenizer package
// Widths, record types and byte classification shared by the tokenizer.
// ----------------------------------------------------------------------------
package ungt_pkg;

  localparam int MAX_GRAM    = 8;
  localparam int POS_BITS    = 16;
  // Positions saturate at 2^POS_BITS + 64, so one extra bit is kept
  localparam int POS_W       = POS_BITS + 1;
  localparam int CNT_W       = $clog2(MAX_GRAM + 1);
  localparam int GRAM_W      = 4;
  localparam int BYTE_W      = 8;
  localparam int ORD_W       = 32;
  localparam int TOK_LEN_W   = 6;
  localparam int IN_DATA_W   = ((BYTE_W + ORD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = POS_BITS + TOK_LEN_W + ORD_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam logic [POS_W-1:0] CAP_POS = POS_W'((1 << POS_BITS) + 64);
  localparam logic [GRAM_W-1:0] GRAM_RESET = GRAM_W'(2);

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic {
    KIND_TOKEN = 1'b0,
    KIND_END   = 1'b1
  } ungt_kind_e;

  typedef struct packed {
    ungt_kind_e            kind;
    logic [POS_BITS-1:0]   start;
    logic [TOK_LEN_W-1:0]  nbytes;
    logic [ORD_W-1:0]      ordinal;
    logic                  last;
  } ungt_rec_t;

  // Records produced by one accepted byte, first one in r0
  typedef struct packed {
    logic [1:0] cnt;
    ungt_rec_t  r0;
    ungt_rec_t  r1;
  } ungt_push_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    is_ws = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Continuation bytes that follow a lead byte
  function automatic logic [1:0] lead_pend(input logic [BYTE_W-1:0] b);
    if (b < 8'hC0) begin
      lead_pend = 2'd0;
    end else if (b < 8'hE0) begin
      lead_pend = 2'd1;
    end else if (b < 8'hF0) begin
      lead_pend = 2'd2;
    end else if (b < 8'hF8) begin
      lead_pend = 2'd3;
    end else begin
      lead_pend = 2'd0;
    end
  endfunction

endpackage

[sv/ungt_cell.sv]
// ----------------------------------------------------------------------------
// Window cell
// Holds the start position of one recent code point. Shifts its neighbor's
// value in on each completed code point and passes the gram tap down the row.
// ----------------------------------------------------------------------------
module ungt_cell
  import ungt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [POS_W-1:0] start_i,
  input  logic             sel_i,
  input  logic [POS_W-1:0] tap_i,
  output logic [POS_W-1:0] start_o,
  output logic [POS_W-1:0] tap_o
);

  logic [POS_W-1:0] start_q, start_d;

  // Take the neighbor's start on a shift, else hold
  assign start_d = shift_i ? start_i : start_q;

  // Offer the updated value when this cell is the selected window end
  assign tap_o   = sel_i ? start_d : tap_i;
  assign start_o = start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else begin
      start_q <= start_d;
    end
  end

endmodule

[sv/ungt_ofifo.sv]
// ----------------------------------------------------------------------------
// Result queue
// Small queue taking up to two records per cycle while it shows room and handing
// one per cycle to the output stream while the stream is ready.
// ----------------------------------------------------------------------------
`include "utf8_ngram_tokenizer_core_macros.svh"

module ungt_ofifo
  import ungt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ungt_push_t push_i,
  output logic       room_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output ungt_rec_t  m_rec_o
);

  ungt_rec_t                mem_q [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [OFIFO_CNT_W-1:0]   cnt_q, cnt_d;
  logic                     pop;
  logic                     last_pop;
  logic [OFIFO_PTR_W-1:0]   wr_next;

  assign pop       = m_valid_o && m_ready_i;
  assign m_valid_o = (cnt_q != '0);
  assign m_rec_o   = mem_q[rd_q];
  // Keep space for the two records one byte may cause
  assign room_o    = (cnt_q <= OFIFO_CNT_W'(OFIFO_DEPTH - 2));
  assign wr_next   = wr_q + OFIFO_PTR_W'(1);
  // Final entry leaves with nothing new arriving
  assign last_pop  = pop && (cnt_q == OFIFO_CNT_W'(1)) && (push_i.cnt == 2'd0);

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q + OFIFO_PTR_W'(push_i.cnt);
    rd_d  = rd_q + OFIFO_PTR_W'(pop);
    cnt_d = cnt_q + OFIFO_CNT_W'(push_i.cnt) - OFIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store new records
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  `UNGT_ASSERT(a_ofifo_cnt_max, cnt_q <= OFIFO_CNT_W'(OFIFO_DEPTH), "queue overfilled")
  `UNGT_ASSERT(a_ofifo_push_room, (push_i.cnt == 2'd0) || room_o, "push without room")
  `UNGT_ASSERT_NEXT(a_ofifo_drain, last_pop, !m_valid_o, "queue not empty after last pop")

endmodule

[sv/utf8_ngram_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// UTF-8 n-gram tokenizer core
// Frames UTF-8 code points from a byte stream and emits every whitespace-free
// window of gram_size code points as a token, plus an end record per text.
// ----------------------------------------------------------------------------
// Output: a result is written into the result queue when its byte is accepted
//   and presented on the master side from there; queued results drain one per cycle while m_axis_tready_i is high.
// Throughput: one byte per cycle while the result queue has room; a byte that
//   yields both a token and an end record pushes both records at once into the
//   four-entry result queue.
// Reset: rst_ni clears the window, counters, ordinal and queue; gram_size = 2.
`include "utf8_ngram_tokenizer_core_macros.svh"

module utf8_ngram_tokenizer_core
  import ungt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config register gram_size
  input  logic                  cfg_we_i,
  input  logic [GRAM_W-1:0]     cfg_wdata_i,
  // input byte stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // text_byte, start_ordinal
  input  logic                  s_axis_tuser_i,   // first_byte
  input  logic                  s_axis_tlast_i,   // last_byte
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // start_pos, token_bytes, ordinal
  output logic                  m_axis_tuser_o,   // record_kind
  output logic                  m_axis_tlast_o    // last_of_run
);

  logic [GRAM_W-1:0] gram_q;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  cps_q, cps_d;
  logic [1:0]        pend_q, pend_d;
  logic [ORD_W-1:0]  ord_q, ord_d;

  logic              acc;
  logic [BYTE_W-1:0] text_byte;
  logic [ORD_W-1:0]  start_ord;
  logic [CNT_W-1:0]  g_eff;
  logic [CNT_W-1:0]  run_base, run_inc;
  logic [POS_W-1:0]  pos_base, pos_inc;
  logic [1:0]        pend_base;
  logic [ORD_W-1:0]  ord_base, ord_after;
  logic              complete, tok;
  logic [POS_W-1:0]  win_end, span;
  logic              room;
  logic              state_idle;
  ungt_push_t        push;
  ungt_rec_t         out_rec;

  logic [MAX_GRAM-1:0] sel;
  logic [POS_W-1:0]    cell_start [MAX_GRAM];
  logic [POS_W-1:0]    cell_tap   [MAX_GRAM];

  assign text_byte       = s_axis_tdata_i[BYTE_W-1:0];
  assign start_ord       = s_axis_tdata_i[BYTE_W+ORD_W-1:BYTE_W];
  assign s_axis_tready_o = room;
  assign acc             = s_axis_tvalid_i && room;

  // Clamp the gram size into 1..MAX_GRAM
  always_comb begin
    if (gram_q == '0) begin
      g_eff = CNT_W'(1);
    end else if ({1'b0, gram_q} > 5'(MAX_GRAM)) begin
      g_eff = CNT_W'(MAX_GRAM);
    end else begin
      g_eff = CNT_W'(gram_q);
    end
  end

  // Frame code points and update the run state
  always_comb begin
    run_base  = s_axis_tuser_i ? '0 : run_q;
    pend_base = s_axis_tuser_i ? 2'd0 : pend_q;
    pos_base  = s_axis_tuser_i ? '0 : pos_q;
    ord_base  = s_axis_tuser_i ? start_ord : ord_q;

    run_d    = run_base;
    pend_d   = pend_base;
    cps_d    = cps_q;
    complete = 1'b0;

    if (pend_base == 2'd0) begin
      if (is_ws(text_byte)) begin
        run_d = '0;
      end else begin
        cps_d  = pos_base;
        pend_d = lead_pend(text_byte);
        complete = (lead_pend(text_byte) == 2'd0);
      end
    end else begin
      pend_d   = pend_base - 2'd1;
      complete = (pend_base == 2'd1);
    end

    run_inc = (run_base < g_eff) ? run_base + CNT_W'(1) : g_eff;
    if (complete) begin
      run_d = run_inc;
    end

    // Emit when the window is full and starts inside the position range
    tok       = complete && (run_inc == g_eff) && !win_end[POS_W-1];
    pos_inc   = pos_base + POS_W'(1);
    span      = pos_inc - win_end;
    ord_after = ord_base + ORD_W'(tok);
    ord_d     = ord_after;
    pos_d     = (pos_base < CAP_POS) ? pos_inc : CAP_POS;

    // Close the text
    if (s_axis_tlast_i) begin
      run_d  = '0;
      pend_d = 2'd0;
      pos_d  = '0;
    end
  end

  // Window cell row, newest code point enters cell 0
  for (genvar i = 0; i < MAX_GRAM; i++) begin : g_cell
    assign sel[i] = (g_eff == CNT_W'(i + 1));
    if (i == 0) begin : g_head
      ungt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (acc && complete),
        .start_i (cps_d),
        .sel_i   (sel[i]),
        .tap_i   ('0),
        .start_o (cell_start[i]),
        .tap_o   (cell_tap[i])
      );
    end else begin : g_body
      ungt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (acc && complete),
        .start_i (cell_start[i-1]),
        .sel_i   (sel[i]),
        .tap_i   (cell_tap[i-1]),
        .start_o (cell_start[i]),
        .tap_o   (cell_tap[i])
      );
    end
  end
  assign win_end = cell_tap[MAX_GRAM-1];

  // Build the records for the queue
  always_comb begin
    push.r0.kind    = KIND_TOKEN;
    push.r0.start   = win_end[POS_BITS-1:0];
    push.r0.nbytes  = span[TOK_LEN_W-1:0];
    push.r0.ordinal = ord_base;
    push.r0.last    = !s_axis_tlast_i;

    push.r1.kind    = KIND_END;
    push.r1.start   = '0;
    push.r1.nbytes  = '0;
    push.r1.ordinal = ord_after;
    push.r1.last    = 1'b1;

    push.cnt = 2'd0;
    if (acc) begin
      if (tok && s_axis_tlast_i) begin
        push.cnt = 2'd2;
      end else if (tok) begin
        push.cnt = 2'd1;
      end else if (s_axis_tlast_i) begin
        push.cnt = 2'd1;
        push.r0  = push.r1;
      end
    end
  end

  ungt_ofifo u_ofifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .room_o    (room),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_rec_o   (out_rec)
  );

  assign m_axis_tdata_o = OUT_DATA_W'({out_rec.ordinal, out_rec.nbytes, out_rec.start});
  assign m_axis_tuser_o = out_rec.kind;
  assign m_axis_tlast_o = out_rec.last;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gram_q <= GRAM_RESET;
    end else if (cfg_we_i) begin
      gram_q <= cfg_wdata_i;
    end
  end

  // Tokenizer state, advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      pos_q  <= '0;
      cps_q  <= '0;
      pend_q <= 2'd0;
      ord_q  <= '0;
    end else if (acc) begin
      run_q  <= run_d;
      pos_q  <= pos_d;
      cps_q  <= cps_d;
      pend_q <= pend_d;
      ord_q  <= ord_d;
    end
  end

  // Text state back at its start values
  assign state_idle = (pos_q == '0) && (pend_q == 2'd0) && (run_q == '0);

  `UNGT_ASSERT(a_run_max, run_q <= CNT_W'(MAX_GRAM), "run count above maximum gram size")
  `UNGT_ASSERT(a_pos_cap, pos_q <= CAP_POS, "byte position beyond saturation point")
  `UNGT_ASSERT_NEXT(a_last_clears, acc && s_axis_tlast_i, state_idle, "text state kept")

endmodule
